### hdl/lif_pkg.sv
package lif_pkg;

  localparam int DATA_W      = 32;
  localparam int ACC_W       = 64;
  localparam int PROD_W      = 112;
  localparam int CFG_IDX_W   = 2;
  localparam int Q_DEPTH_DEF = 4;

  localparam logic signed [ACC_W-1:0] INT64_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] INT64_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  // Reset values: 1.0, -0.5 and -1.0 in Q16.16
  localparam logic [DATA_W-1:0] INV_SIGMA_SQ_RST = 32'h0001_0000;
  localparam logic [DATA_W-1:0] FORCE_SCALE_RST  = 32'hFFFF_8000;
  localparam logic [DATA_W-1:0] COEF_SCALE_RST   = 32'hFFFF_0000;

  // History depth: forces need the step two back
  localparam logic [1:0] STEPS_FULL = 2'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INV_SIGMA_SQ = 2'd0,
    CFG_FORCE_SCALE  = 2'd1,
    CFG_COEF_SCALE   = 2'd2
  } lif_cfg_idx_t;

  typedef struct packed {
    logic        [DATA_W-1:0] inv_sigma_sq;
    logic signed [DATA_W-1:0] force_scale;
    logic signed [DATA_W-1:0] coef_scale;
  } lif_cfg_t;

  // One particle's impulse contribution, as it travels from front to back
  typedef struct packed {
    logic signed [ACC_W-1:0] term_x;
    logic signed [ACC_W-1:0] term_y;
    logic                    last;
  } lif_term_t;

  typedef enum logic [1:0] {
    BK_ACC  = 2'd0,
    BK_DIFF = 2'd1,
    BK_MUL  = 2'd2,
    BK_DONE = 2'd3
  } lif_back_state_t;

  // Floor shift right by 16 of an exact product, saturated to signed 64 bits
  function automatic logic signed [ACC_W-1:0] lif_sat_q16(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] s;
    logic signed [ACC_W-1:0]  r;
    s = p >>> 16;
    if (s[PROD_W-1:ACC_W-1] == {(PROD_W-ACC_W+1){s[ACC_W-1]}}) begin
      r = s[ACC_W-1:0];
    end else begin
      r = p[PROD_W-1] ? INT64_MIN : INT64_MAX;
    end
    return r;
  endfunction

endpackage

### hdl/lif_front.sv
module lif_front (
  input  logic                clk,
  input  logic                rst_n,
  input  lif_pkg::lif_cfg_t   cfg,
  input  logic                push,
  output logic                ready,
  input  logic signed [31:0]  pos_x,
  input  logic signed [31:0]  pos_y,
  input  logic signed [31:0]  circulation,
  input  logic        [31:0]  core_size,
  input  logic                last_particle,
  output logic                q_push,
  output lif_pkg::lif_term_t  q_wdata,
  input  logic                q_full
);
  import lif_pkg::*;

  localparam int NSTG = 5;

  logic [NSTG-1:0] vld_r, vld_nxt;
  logic [NSTG-1:0] last_r;
  logic            adv;

  // Stage 1: size squared and position times circulation
  logic        [63:0] sz_sq;
  logic signed [63:0] yg;
  logic signed [32:0] nx;
  logic signed [64:0] xg;
  logic        [47:0] s1_sz2_r;
  logic signed [47:0] s1_g_r [2];

  // Stage 2: area partial products
  logic        [63:0] s2_alo_r;
  logic        [47:0] s2_ahi_r;
  logic signed [47:0] s2_g_r [2];

  // Stage 3: area, saturated
  logic        [79:0] asum;
  logic        [62:0] area_nxt;
  logic        [62:0] s3_area_r;
  logic signed [47:0] s3_g_r [2];

  // Stage 4: term partial products, lane 0 for x, lane 1 for y
  logic        [63:0] pll_nxt [2];
  logic        [62:0] plh_nxt [2];
  logic signed [48:0] phl_nxt [2];
  logic signed [47:0] phh_nxt [2];
  logic        [63:0] s4_pll_r [2];
  logic        [62:0] s4_plh_r [2];
  logic signed [48:0] s4_phl_r [2];
  logic signed [47:0] s4_phh_r [2];

  // Stage 5: exact term products
  logic signed [PROD_W-1:0] sum_nxt [2];
  logic signed [PROD_W-1:0] s5_sum_r [2];

  // Advance the whole pipe unless the last stage is blocked by the queue
  assign adv     = !(vld_r[NSTG-1] && q_full);
  assign ready   = adv;
  assign q_push  = vld_r[NSTG-1] && !q_full;
  assign vld_nxt = {vld_r[NSTG-2:0], push};

  assign q_wdata.term_x = lif_sat_q16(s5_sum_r[0]);
  assign q_wdata.term_y = lif_sat_q16(s5_sum_r[1]);
  assign q_wdata.last   = last_r[NSTG-1];

  always_comb begin
    sz_sq = core_size * core_size;
    yg    = pos_y * circulation;
    nx    = -{pos_x[31], pos_x};
    xg    = nx * circulation;
  end

  always_comb begin
    asum     = {16'b0, s2_alo_r} + {s2_ahi_r, 32'b0};
    area_nxt = asum[79] ? {63{1'b1}} : asum[78:16];
  end

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      pll_nxt[k] = s3_g_r[k][31:0] * s3_area_r[31:0];
      plh_nxt[k] = s3_g_r[k][31:0] * s3_area_r[62:32];
      phl_nxt[k] = $signed(s3_g_r[k][47:32]) * $signed({1'b0, s3_area_r[31:0]});
      phh_nxt[k] = $signed(s3_g_r[k][47:32]) * $signed({1'b0, s3_area_r[62:32]});
      sum_nxt[k] = $signed(PROD_W'(s4_pll_r[k]))
                 + ($signed(PROD_W'(s4_plh_r[k])) <<< 32)
                 + (PROD_W'(s4_phl_r[k]) <<< 32)
                 + (PROD_W'(s4_phh_r[k]) <<< 64);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      last_r      <= {last_r[NSTG-2:0], last_particle};
      s1_sz2_r    <= sz_sq[63:16];
      s1_g_r[0]   <= yg[63:16];
      s1_g_r[1]   <= xg[63:16];
      s2_alo_r    <= s1_sz2_r[31:0] * cfg.inv_sigma_sq;
      s2_ahi_r    <= s1_sz2_r[47:32] * cfg.inv_sigma_sq;
      s2_g_r      <= s1_g_r;
      s3_area_r   <= area_nxt;
      s3_g_r      <= s2_g_r;
      s4_pll_r    <= pll_nxt;
      s4_plh_r    <= plh_nxt;
      s4_phl_r    <= phl_nxt;
      s4_phh_r    <= phh_nxt;
      s5_sum_r    <= sum_nxt;
    end
  end

endmodule

### hdl/lif_queue.sv
module lif_queue #(
  parameter int DEPTH = lif_pkg::Q_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  lif_pkg::lif_term_t wdata,
  output logic               full,
  input  logic               pop,
  output lif_pkg::lif_term_t rdata,
  output logic               empty
);
  import lif_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  lif_term_t        mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign rdata   = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

### hdl/lif_back.sv
module lif_back (
  input  logic                clk,
  input  logic                rst_n,
  input  lif_pkg::lif_cfg_t   cfg,
  input  lif_pkg::lif_term_t  q_rdata,
  input  logic                q_empty,
  output logic                q_pop,
  input  logic                out_pop,
  output logic                out_empty,
  output logic signed [63:0]  impulse_x,
  output logic signed [63:0]  impulse_y,
  output logic signed [63:0]  force_x,
  output logic signed [63:0]  force_y,
  output logic signed [63:0]  coef_x,
  output logic signed [63:0]  coef_y,
  output logic                forces_valid
);
  import lif_pkg::*;

  lif_back_state_t state_r, state_nxt;

  logic signed [ACC_W-1:0] acc_x_r, acc_y_r;
  logic signed [ACC_W-1:0] hist0_x_r, hist0_y_r, hist1_x_r, hist1_y_r;
  logic signed [ACC_W-1:0] dx_r, dy_r;
  logic [1:0]              steps_r, steps_nxt;
  logic                    out_valid_r;

  // Product lanes: force x, force y, coef x, coef y
  logic signed [64:0]       plo_nxt [4];
  logic signed [63:0]       phi_nxt [4];
  logic signed [64:0]       plo_r [4];
  logic signed [63:0]       phi_r [4];
  logic signed [ACC_W-1:0]  res [4];
  logic signed [DATA_W-1:0] scl;
  logic signed [ACC_W-1:0]  dv;

  logic signed [ACC_W-1:0] imp_x_r, imp_y_r, frc_x_r, frc_y_r, cf_x_r, cf_y_r;
  logic                    fvld_r;
  logic                    do_acc, do_diff, do_mul, do_done, valid_now;

  function automatic logic signed [ACC_W-1:0] sat_add(input logic signed [ACC_W-1:0] a,
                                                      input logic signed [ACC_W-1:0] b);
    logic signed [ACC_W:0] s;
    s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
    return (s[ACC_W] != s[ACC_W-1]) ? (s[ACC_W] ? INT64_MIN : INT64_MAX) : s[ACC_W-1:0];
  endfunction

  function automatic logic signed [ACC_W-1:0] sat_sub(input logic signed [ACC_W-1:0] a,
                                                      input logic signed [ACC_W-1:0] b);
    logic signed [ACC_W:0] s;
    s = {a[ACC_W-1], a} - {b[ACC_W-1], b};
    return (s[ACC_W] != s[ACC_W-1]) ? (s[ACC_W] ? INT64_MIN : INT64_MAX) : s[ACC_W-1:0];
  endfunction

  assign out_empty    = !out_valid_r;
  assign impulse_x    = imp_x_r;
  assign impulse_y    = imp_y_r;
  assign force_x      = frc_x_r;
  assign force_y      = frc_y_r;
  assign coef_x       = cf_x_r;
  assign coef_y       = cf_y_r;
  assign forces_valid = fvld_r;
  assign valid_now    = (steps_r == STEPS_FULL);
  assign steps_nxt    = valid_now ? steps_r : steps_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_ACC;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    do_acc    = 1'b0;
    do_diff   = 1'b0;
    do_mul    = 1'b0;
    do_done   = 1'b0;
    case (state_r)
      BK_ACC: begin
        if (!q_empty) begin
          q_pop  = 1'b1;
          do_acc = 1'b1;
          if (q_rdata.last) begin
            state_nxt = BK_DIFF;
          end
        end
      end
      BK_DIFF: begin
        do_diff   = 1'b1;
        state_nxt = BK_MUL;
      end
      BK_MUL: begin
        do_mul    = 1'b1;
        state_nxt = BK_DONE;
      end
      BK_DONE: begin
        // Hold the finished step until the output register frees up
        if (!out_valid_r || out_pop) begin
          do_done   = 1'b1;
          state_nxt = BK_ACC;
        end
      end
      default: begin
        state_nxt = BK_ACC;
      end
    endcase
  end

  always_comb begin
    scl = cfg.force_scale;
    dv  = dx_r;
    for (int k = 0; k < 4; k++) begin
      scl        = (k < 2) ? cfg.force_scale : cfg.coef_scale;
      dv         = (k == 0 || k == 2) ? dx_r : dy_r;
      plo_nxt[k] = scl * $signed({1'b0, dv[31:0]});
      phi_nxt[k] = scl * $signed(dv[63:32]);
      res[k]     = lif_sat_q16(PROD_W'(plo_r[k]) + (PROD_W'(phi_r[k]) <<< 32));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_x_r     <= '0;
      acc_y_r     <= '0;
      hist0_x_r   <= '0;
      hist0_y_r   <= '0;
      hist1_x_r   <= '0;
      hist1_y_r   <= '0;
      steps_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (do_acc) begin
        acc_x_r <= sat_add(acc_x_r, q_rdata.term_x);
        acc_y_r <= sat_add(acc_y_r, q_rdata.term_y);
      end else if (do_done) begin
        acc_x_r <= '0;
        acc_y_r <= '0;
      end
      if (do_done) begin
        hist1_x_r <= hist0_x_r;
        hist1_y_r <= hist0_y_r;
        hist0_x_r <= acc_x_r;
        hist0_y_r <= acc_y_r;
        steps_r   <= steps_nxt;
      end
      if (do_done) begin
        out_valid_r <= 1'b1;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_diff) begin
      dx_r <= sat_sub(acc_x_r, hist1_x_r);
      dy_r <= sat_sub(acc_y_r, hist1_y_r);
    end
    if (do_mul) begin
      plo_r <= plo_nxt;
      phi_r <= phi_nxt;
    end
    if (do_done) begin
      imp_x_r <= acc_x_r;
      imp_y_r <= acc_y_r;
      frc_x_r <= valid_now ? res[0] : '0;
      frc_y_r <= valid_now ? res[1] : '0;
      cf_x_r  <= valid_now ? res[2] : '0;
      cf_y_r  <= valid_now ? res[3] : '0;
      fvld_r  <= valid_now;
    end
  end

endmodule

### hdl/linear_impulse_force.sv
// Linear impulse force estimator for a stream of 2-D vortex particles.
//
// Input channel (in_*): push one particle per item with in_push while in_full
// is low. in_last_particle closes a time step. Result channel (out_*): one
// item per time step, shown while out_empty is low, taken with out_pop.
// Configuration (cfg_*): write inv_sigma_sq, force_scale or coef_scale by
// index while the block is idle; writes to an unused index are dropped.
//
// A five-stage product pipe takes one particle per cycle while in_full is
// low and hands each particle's impulse terms to a short queue. The
// accumulator drains the queue at one item per cycle while accumulating; at
// the end of a step it moves through difference, scale multiply, and
// saturate and write out, waiting there while the output register is full.
//
// Reset (rst_n low, synchronous) restores the register defaults and clears
// the sums, the two-step history and the queue. When the receiver holds
// off, the result waits in the output register, the accumulator stops at
// the next step end, the queue fills and in_full rises.
module linear_impulse_force #(
  parameter int QUEUE_DEPTH = lif_pkg::Q_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [lif_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lif_pkg::DATA_W-1:0]         cfg_wdata,
  input  logic                               in_push,
  output logic                               in_full,
  input  logic signed [lif_pkg::DATA_W-1:0]  in_pos_x,
  input  logic signed [lif_pkg::DATA_W-1:0]  in_pos_y,
  input  logic signed [lif_pkg::DATA_W-1:0]  in_circulation,
  input  logic        [lif_pkg::DATA_W-1:0]  in_core_size,
  input  logic                               in_last_particle,
  output logic                               out_empty,
  input  logic                               out_pop,
  output logic signed [lif_pkg::ACC_W-1:0]   out_impulse_x,
  output logic signed [lif_pkg::ACC_W-1:0]   out_impulse_y,
  output logic signed [lif_pkg::ACC_W-1:0]   out_force_x,
  output logic signed [lif_pkg::ACC_W-1:0]   out_force_y,
  output logic signed [lif_pkg::ACC_W-1:0]   out_coef_x,
  output logic signed [lif_pkg::ACC_W-1:0]   out_coef_y,
  output logic                               out_forces_valid
);
  import lif_pkg::*;

  lif_cfg_t  cfg_r;
  lif_term_t q_wdata, q_rdata;
  logic      q_push, q_full, q_pop, q_empty;
  logic      front_ready;

  // Config registers: hold the defaults until written
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.inv_sigma_sq <= INV_SIGMA_SQ_RST;
      cfg_r.force_scale  <= FORCE_SCALE_RST;
      cfg_r.coef_scale   <= COEF_SCALE_RST;
    end else if (cfg_we) begin
      case (lif_cfg_idx_t'(cfg_index))
        CFG_INV_SIGMA_SQ: cfg_r.inv_sigma_sq <= cfg_wdata;
        CFG_FORCE_SCALE:  cfg_r.force_scale  <= cfg_wdata;
        CFG_COEF_SCALE:   cfg_r.coef_scale   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // The front refuses a particle only when its last stage is blocked
  assign in_full = !front_ready;

  lif_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .push          (in_push),
    .ready         (front_ready),
    .pos_x         (in_pos_x),
    .pos_y         (in_pos_y),
    .circulation   (in_circulation),
    .core_size     (in_core_size),
    .last_particle (in_last_particle),
    .q_push        (q_push),
    .q_wdata       (q_wdata),
    .q_full        (q_full)
  );

  lif_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  lif_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .q_rdata      (q_rdata),
    .q_empty      (q_empty),
    .q_pop        (q_pop),
    .out_pop      (out_pop),
    .out_empty    (out_empty),
    .impulse_x    (out_impulse_x),
    .impulse_y    (out_impulse_y),
    .force_x      (out_force_x),
    .force_y      (out_force_y),
    .coef_x       (out_coef_x),
    .coef_y       (out_coef_y),
    .forces_valid (out_forces_valid)
  );

`ifndef SYNTHESIS
  // The front never writes into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("term written into full queue");

  // The accumulator never reads an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("term read from empty queue");

  // Early steps carry zero forces and coefficients
  a_early_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_forces_valid) |->
      (out_force_x == '0 && out_force_y == '0 && out_coef_x == '0 && out_coef_y == '0))
    else $error("nonzero force on a step without history");
`endif

endmodule

### test/impulse_checker.sv
module impulse_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [lif_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lif_pkg::DATA_W-1:0]        cfg_wdata,
  input  logic                              in_push,
  input  logic                              in_full,
  input  logic signed [lif_pkg::DATA_W-1:0] in_pos_x,
  input  logic signed [lif_pkg::DATA_W-1:0] in_pos_y,
  input  logic signed [lif_pkg::DATA_W-1:0] in_circulation,
  input  logic [lif_pkg::DATA_W-1:0]        in_core_size,
  input  logic                              in_last_particle,
  input  logic                              out_empty,
  input  logic                              out_pop,
  input  logic signed [lif_pkg::ACC_W-1:0]  out_impulse_x,
  input  logic signed [lif_pkg::ACC_W-1:0]  out_impulse_y,
  input  logic signed [lif_pkg::ACC_W-1:0]  out_force_x,
  input  logic signed [lif_pkg::ACC_W-1:0]  out_force_y,
  input  logic signed [lif_pkg::ACC_W-1:0]  out_coef_x,
  input  logic signed [lif_pkg::ACC_W-1:0]  out_coef_y,
  input  logic                              out_forces_valid,
  output int                                fail_count,
  output int                                steps_owed
);
  import lif_pkg::*;

  localparam logic signed [127:0] WIDE_MAX = 128'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [127:0] WIDE_MIN = ~WIDE_MAX;

  typedef struct packed {
    logic signed [ACC_W-1:0] imp_x;
    logic signed [ACC_W-1:0] imp_y;
    logic signed [ACC_W-1:0] frc_x;
    logic signed [ACC_W-1:0] frc_y;
    logic signed [ACC_W-1:0] cf_x;
    logic signed [ACC_W-1:0] cf_y;
    logic                    valid;
  } step_report_t;

  step_report_t owed_q[$];

  logic [DATA_W-1:0]        inv_sigma;
  logic signed [DATA_W-1:0] f_scale;
  logic signed [DATA_W-1:0] c_scale;
  logic signed [ACC_W-1:0]  sum_x, sum_y;
  logic signed [ACC_W-1:0]  back1_x, back1_y, back2_x, back2_y;
  logic [1:0]               steps_done;
  int                       checked;

  function automatic logic signed [ACC_W-1:0] clamp64(input logic signed [127:0] v);
    if (v > WIDE_MAX) return WIDE_MAX[ACC_W-1:0];
    if (v < WIDE_MIN) return WIDE_MIN[ACC_W-1:0];
    return v[ACC_W-1:0];
  endfunction

  // Exact product, floor shift by the fraction bits, then clamp
  function automatic logic signed [ACC_W-1:0] q16_mul(input logic signed [ACC_W-1:0] a,
                                                      input logic signed [ACC_W-1:0] b);
    logic signed [127:0] p;
    p = $signed({{64{a[63]}}, a}) * $signed({{64{b[63]}}, b});
    return clamp64(p >>> 16);
  endfunction

  function automatic logic signed [ACC_W-1:0] sat_sum(input logic signed [ACC_W-1:0] a,
                                                      input logic signed [ACC_W-1:0] b);
    return clamp64($signed({{64{a[63]}}, a}) + $signed({{64{b[63]}}, b}));
  endfunction

  function automatic logic signed [ACC_W-1:0] sat_diff(input logic signed [ACC_W-1:0] a,
                                                       input logic signed [ACC_W-1:0] b);
    return clamp64($signed({{64{a[63]}}, a}) - $signed({{64{b[63]}}, b}));
  endfunction

  task automatic report(input string msg);
    $display("ERROR at %0t: %s", $realtime, msg);
    fail_count++;
  endtask

  always @(posedge clk) begin
    step_report_t            want;
    logic signed [ACC_W-1:0] px, py, circ, size, area, dx, dy;
    if (!rst_n) begin
      inv_sigma  = INV_SIGMA_SQ_RST;
      f_scale    = FORCE_SCALE_RST;
      c_scale    = COEF_SCALE_RST;
      sum_x      = '0;
      sum_y      = '0;
      back1_x    = '0;
      back1_y    = '0;
      back2_x    = '0;
      back2_y    = '0;
      steps_done = '0;
      owed_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_INV_SIGMA_SQ: inv_sigma = cfg_wdata;
          CFG_FORCE_SCALE:  f_scale = cfg_wdata;
          CFG_COEF_SCALE:   c_scale = cfg_wdata;
          default: ;
        endcase
      end

      if (out_pop && !out_empty) begin
        if (owed_q.size() == 0) begin
          report("result item with no step waiting for it");
        end else begin
          want = owed_q.pop_front();
          if (out_impulse_x !== want.imp_x)
            report($sformatf("step %0d impulse_x got %0d expected %0d",
                             checked, out_impulse_x, want.imp_x));
          if (out_impulse_y !== want.imp_y)
            report($sformatf("step %0d impulse_y got %0d expected %0d",
                             checked, out_impulse_y, want.imp_y));
          if (out_force_x !== want.frc_x)
            report($sformatf("step %0d force_x got %0d expected %0d",
                             checked, out_force_x, want.frc_x));
          if (out_force_y !== want.frc_y)
            report($sformatf("step %0d force_y got %0d expected %0d",
                             checked, out_force_y, want.frc_y));
          if (out_coef_x !== want.cf_x)
            report($sformatf("step %0d coef_x got %0d expected %0d",
                             checked, out_coef_x, want.cf_x));
          if (out_coef_y !== want.cf_y)
            report($sformatf("step %0d coef_y got %0d expected %0d",
                             checked, out_coef_y, want.cf_y));
          if (out_forces_valid !== want.valid)
            report($sformatf("step %0d forces_valid got %b expected %b",
                             checked, out_forces_valid, want.valid));
        end
        checked++;
      end

      if (in_push && !in_full) begin
        px   = {{32{in_pos_x[31]}}, in_pos_x};
        py   = {{32{in_pos_y[31]}}, in_pos_y};
        circ = {{32{in_circulation[31]}}, in_circulation};
        size = {32'd0, in_core_size};
        area = q16_mul(q16_mul(size, size), {32'd0, inv_sigma});
        sum_x = sat_sum(sum_x, q16_mul(q16_mul(py, circ), area));
        sum_y = sat_sum(sum_y, q16_mul(q16_mul(-px, circ), area));
        if (in_last_particle) begin
          want       = '0;
          want.imp_x = sum_x;
          want.imp_y = sum_y;
          // forces only once the step two back exists
          if (steps_done == STEPS_FULL) begin
            dx         = sat_diff(sum_x, back2_x);
            dy         = sat_diff(sum_y, back2_y);
            want.frc_x = q16_mul({{32{f_scale[31]}}, f_scale}, dx);
            want.frc_y = q16_mul({{32{f_scale[31]}}, f_scale}, dy);
            want.cf_x  = q16_mul({{32{c_scale[31]}}, c_scale}, dx);
            want.cf_y  = q16_mul({{32{c_scale[31]}}, c_scale}, dy);
            want.valid = 1'b1;
          end
          owed_q = {owed_q, want};
          back2_x = back1_x;
          back2_y = back1_y;
          back1_x = sum_x;
          back1_y = sum_y;
          if (steps_done != STEPS_FULL) steps_done++;
          sum_x = '0;
          sum_y = '0;
        end
      end
    end
    steps_owed <= owed_q.size();
  end

endmodule

### test/testbench.sv
module testbench;
  import lif_pkg::*;

  // Index with no register behind it: the block must drop the write
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 160;
  localparam int SETTLE      = 20;      // covers the closing-item latency plus step tail
  localparam int LONG_HOLD   = 300;     // receiver hold-off, long enough to fill the block
  localparam int CYCLE_LIMIT = 200000;

  logic                     clk = 1'b0;
  logic                     rst_n;
  logic                     cfg_we;
  logic [CFG_IDX_W-1:0]     cfg_index;
  logic [DATA_W-1:0]        cfg_wdata;
  logic                     in_push;
  logic                     in_full;
  logic signed [DATA_W-1:0] in_pos_x, in_pos_y, in_circulation;
  logic [DATA_W-1:0]        in_core_size;
  logic                     in_last_particle;
  logic                     out_empty;
  logic                     out_pop;
  logic signed [ACC_W-1:0]  out_impulse_x, out_impulse_y;
  logic signed [ACC_W-1:0]  out_force_x, out_force_y;
  logic signed [ACC_W-1:0]  out_coef_x, out_coef_y;
  logic                     out_forces_valid;

  int fail_count;
  int steps_owed;
  int sent_items   = 0;
  int taken_steps  = 0;
  int cycle_count  = 0;

  always #2 clk = ~clk;

  linear_impulse_force uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_pos_x         (in_pos_x),
    .in_pos_y         (in_pos_y),
    .in_circulation   (in_circulation),
    .in_core_size     (in_core_size),
    .in_last_particle (in_last_particle),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_impulse_x    (out_impulse_x),
    .out_impulse_y    (out_impulse_y),
    .out_force_x      (out_force_x),
    .out_force_y      (out_force_y),
    .out_coef_x       (out_coef_x),
    .out_coef_y       (out_coef_y),
    .out_forces_valid (out_forces_valid)
  );

  impulse_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_pos_x         (in_pos_x),
    .in_pos_y         (in_pos_y),
    .in_circulation   (in_circulation),
    .in_core_size     (in_core_size),
    .in_last_particle (in_last_particle),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_impulse_x    (out_impulse_x),
    .out_impulse_y    (out_impulse_y),
    .out_force_x      (out_force_x),
    .out_force_y      (out_force_y),
    .out_coef_x       (out_coef_x),
    .out_coef_y       (out_coef_y),
    .out_forces_valid (out_forces_valid),
    .fail_count       (fail_count),
    .steps_owed       (steps_owed)
  );

  // Watchdog: a hung handshake or a lost result ends here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Coordinates and strengths: mostly moderate values so the sums stay
  // meaningful, with full-range words and the extremes mixed in.
  function automatic logic [DATA_W-1:0] rand_coord();
    logic [DATA_W-1:0] v;
    case ($urandom_range(0, 7))
      0, 1: v = $urandom;
      2: begin
        case ($urandom_range(0, 4))
          0:       v = 32'h8000_0000;
          1:       v = 32'h7FFF_FFFF;
          2:       v = 32'h0000_0000;
          3:       v = 32'hFFFF_FFFF;
          default: v = 32'h0001_0000;
        endcase
      end
      default: v = $urandom_range(0, 32'h001F_FFFF) - 32'h0010_0000;
    endcase
    return v;
  endfunction

  // Core sizes: mostly up to 4.0, sometimes any word or an extreme
  function automatic logic [DATA_W-1:0] rand_core();
    logic [DATA_W-1:0] v;
    case ($urandom_range(0, 6))
      5: v = $urandom;
      6: begin
        case ($urandom_range(0, 2))
          0:       v = 32'h0000_0000;
          1:       v = 32'hFFFF_FFFF;
          default: v = 32'h0001_0000;
        endcase
      end
      default: v = $urandom_range(0, 32'h0004_0000);
    endcase
    return v;
  endfunction

  // Offer one particle and hold it until the block takes it. in_push stays
  // high into the next item when that item draws no gap.
  task automatic send_particle(input logic [DATA_W-1:0] px, input logic [DATA_W-1:0] py,
                               input logic [DATA_W-1:0] circ,
                               input logic [DATA_W-1:0] core, input logic last);
    int gap;
    // every hundred items, run a stretch of back-to-back items
    gap = (sent_items % 100 < 25) ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push          <= 1'b1;
    in_pos_x         <= px;
    in_pos_y         <= py;
    in_circulation   <= circ;
    in_core_size     <= core;
    in_last_particle <= last;
    do @(posedge clk); while (in_full);
    sent_items++;
  endtask

  // Stop offering, wait for every owed result, then let the step tail drain
  task automatic drain_and_settle();
    in_push <= 1'b0;
    @(posedge clk);
    while (steps_owed != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Write one register; the caller lowers cfg_we after the last write
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  task automatic program_phase(input int phase);
    case (phase)
      1: begin
        // zero area, scales at the positive and negative limits
        cfg_write(CFG_INV_SIGMA_SQ, 32'h0000_0000);
        cfg_write(CFG_FORCE_SCALE, 32'h7FFF_FFFF);
        cfg_write(CFG_COEF_SCALE, 32'h8000_0000);
        cfg_write(CFG_UNUSED, $urandom);
      end
      2: begin
        cfg_write(CFG_INV_SIGMA_SQ, 32'hFFFF_FFFF);
        cfg_write(CFG_FORCE_SCALE, 32'h8000_0000);
        cfg_write(CFG_COEF_SCALE, 32'h7FFF_FFFF);
      end
      3: begin
        cfg_write(CFG_INV_SIGMA_SQ, 32'h0001_0000);
        cfg_write(CFG_FORCE_SCALE, 32'h0000_0000);
        cfg_write(CFG_COEF_SCALE, 32'h0001_0000);
      end
      4: begin
        cfg_write(CFG_INV_SIGMA_SQ, $urandom_range(0, 32'h0004_0000));
        cfg_write(CFG_FORCE_SCALE, $urandom);
        cfg_write(CFG_COEF_SCALE, $urandom);
      end
      5: begin
        cfg_write(CFG_INV_SIGMA_SQ, $urandom);
        cfg_write(CFG_FORCE_SCALE, $urandom_range(0, 32'h0003_FFFF) - 32'h0002_0000);
        cfg_write(CFG_COEF_SCALE, $urandom_range(0, 32'h0003_FFFF) - 32'h0002_0000);
        cfg_write(CFG_UNUSED, $urandom);
      end
      6: begin
        cfg_write(CFG_INV_SIGMA_SQ, 32'h0000_8000);
        cfg_write(CFG_FORCE_SCALE, 32'hFFFF_8000);
        cfg_write(CFG_COEF_SCALE, 32'h0001_8000);
      end
      default: begin
        cfg_write(CFG_INV_SIGMA_SQ, $urandom);
        cfg_write(CFG_FORCE_SCALE, $urandom);
        cfg_write(CFG_COEF_SCALE, $urandom);
      end
    endcase
    cfg_we <= 1'b0;
  endtask

  // Whole time steps with random content: mostly short, now and then long
  task automatic run_steps(input int budget);
    int left;
    int len;
    left = budget;
    while (left > 0) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(16, 40) : $urandom_range(1, 10);
      if (len > left) len = left;
      for (int k = 1; k <= len; k++)
        send_particle(rand_coord(), rand_coord(), rand_coord(), rand_core(), k == len);
      left -= len;
    end
  endtask

  // Receiver: take one result item per pass. Hold off for a long stretch
  // twice so the block backs up into in_full.
  initial begin
    int wait_cycles;
    out_pop <= 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (taken_steps == 40 || taken_steps == 140)
        wait_cycles = LONG_HOLD;
      else if (taken_steps % 40 < 10)
        wait_cycles = 0;
      else
        wait_cycles = $urandom_range(0, 9);
      if (wait_cycles > 0) begin
        out_pop <= 1'b0;
        repeat (wait_cycles) @(posedge clk);
      end
      out_pop <= 1'b1;
      do @(posedge clk); while (out_empty);
      taken_steps++;
    end
  end

  initial begin
    rst_n            <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_index        <= CFG_INV_SIGMA_SQ;
    cfg_wdata        <= '0;
    in_push          <= 1'b0;
    in_pos_x         <= '0;
    in_pos_y         <= '0;
    in_circulation   <= '0;
    in_core_size     <= '0;
    in_last_particle <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed steps at the reset scales.
    // An all-zero step; forces stay invalid for the first two steps.
    send_particle(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1);
    // Two ordinary particles with exact fractions
    send_particle(32'h0001_0000, 32'h0002_0000, 32'h0001_0000, 32'h0001_0000, 1'b0);
    send_particle(32'hFFFD_0000, 32'hFFFE_8000, 32'h0000_8000, 32'h0002_0000, 1'b1);
    // Largest sizes and strengths: products and sums saturate, x low, y high
    send_particle(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0);
    send_particle(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1);
    // Zero-size particle contributes nothing
    send_particle(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0000, 1'b1);
    // Opposite saturation: the difference against two steps back saturates too
    send_particle(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0);
    send_particle(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1);
    // Alternating bit patterns on every field
    send_particle(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 1'b0);
    send_particle(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 1'b1);
    // Small negative values, single-particle step
    send_particle(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001, 1'b1);
    run_steps(PHASE_ITEMS);
    drain_and_settle();

    // Each later phase: new scales while idle, then random steps. The sums
    // and history carry over from one phase to the next.
    for (int phase = 1; phase < PHASES; phase++) begin
      program_phase(phase);
      run_steps(PHASE_ITEMS);
      drain_and_settle();
    end

    if (fail_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### files.f
hdl/lif_pkg.sv
hdl/lif_front.sv
hdl/lif_queue.sv
hdl/lif_back.sv
hdl/linear_impulse_force.sv
test/impulse_checker.sv
test/testbench.sv
